// ===== hw/rtl/sssd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sssd_pkg;

  localparam int unsigned DIGIT_IDX_W = 3;
  localparam int unsigned VALUE_W     = 14;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_SCAN = 2'd1;
  localparam logic [1:0] KIND_SLOW = 2'd2;

  localparam logic [1:0] REG_DIGITS_IN_USE = 2'd0;
  localparam logic [1:0] REG_TICKS_PER_PH  = 2'd1;
  localparam logic [1:0] REG_HOLD_PHASES   = 2'd2;
  localparam logic [1:0] REG_BLINK_INDEX   = 2'd3;

  typedef struct packed {
    logic                   load_start;
    logic                   load_step;
    logic [1:0]             step;
    logic                   slow_tick;
    logic                   emit_scan;
    logic                   emit_status;
    logic [DIGIT_IDX_W-1:0] idx;
    logic                   scan_last;
  } cmd_t;

  typedef struct packed {
    logic [3:0] scan_count;
  } sts_t;

  function automatic logic [7:0] seg_encode(input logic [3:0] code);
    logic [7:0] seg;
    case (code)
      4'h0:    seg = 8'h3F;
      4'h1:    seg = 8'h06;
      4'h2:    seg = 8'h5B;
      4'h3:    seg = 8'h4F;
      4'h4:    seg = 8'h66;
      4'h5:    seg = 8'h6D;
      4'h6:    seg = 8'h7D;
      4'h7:    seg = 8'h07;
      4'h8:    seg = 8'h7F;
      4'h9:    seg = 8'h6F;
      4'hA:    seg = 8'h77;
      4'hB:    seg = 8'h7C;
      4'hC:    seg = 8'h39;
      4'hD:    seg = 8'h5E;
      4'hE:    seg = 8'h79;
      4'hF:    seg = 8'h71;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/seven_segment_scan_driver_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Multiplexed seven-segment display driver.
// Input stream (s_axis): tuser carries the kind (load, scan tick, slow tick);
// tdata carries low_value, high_value and button_pressed. One item at a time.
// Output stream (m_axis): one transaction per result; tlast marks the final
// result of an input item. Scan ticks give one transaction per digit in use
// with the buffered segment byte and an active-low digit select; all other
// items give one status transaction (segments 0, select all high).
// Sequence: a load is accepted, then takes four digit-split steps through the
// divide-by-ten datapath, then issues its status; a scan tick issues one result
// per digit in use, a slow tick or unknown kind one status. The sequencer issues
// one result per cycle, while the output is free, into a single output register.
// The output register holds its transaction while m_axis_tready is low and
// the sequencer waits; the input side is taken again once the item is issued.
// Configuration writes (cfg_we, cfg_addr, cfg_wdata) take effect at once and
// are expected only while no item is in flight.
// Reset clears the segment buffer, counters and flags and loads the register
// defaults (6 digits, 250 ticks per phase, 6 hold phases, blink digit 0).
module seven_segment_scan_driver_core #(
  parameter int unsigned NUM_DIGITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // low_value, high_value, button_pressed
  input  wire logic [1:0]  s_axis_tuser,  // kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // segments, digit_select, disp_mode, heartbeat
  output logic             m_axis_tlast,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [7:0]  cfg_wdata
);

  sssd_pkg::cmd_t cmd;
  sssd_pkg::sts_t sts;
  logic [7:0]     segments;
  logic [7:0]     digit_select;
  logic           disp_mode;
  logic           heartbeat;

  sssd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_kind   (s_axis_tuser),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sssd_dp #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .low_value      (s_axis_tdata[13:0]),
    .high_value     (s_axis_tdata[27:14]),
    .button_pressed (s_axis_tdata[28]),
    .cmd            (cmd),
    .sts            (sts),
    .segments       (segments),
    .digit_select   (digit_select),
    .last           (m_axis_tlast),
    .disp_mode      (disp_mode),
    .heartbeat      (heartbeat)
  );

  assign m_axis_tdata = {6'd0, heartbeat, disp_mode, digit_select, segments};

endmodule

`default_nettype wire

// ===== hw/rtl/sssd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sssd_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [1:0]    in_kind,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire sssd_pkg::sts_t sts,
  output sssd_pkg::cmd_t     cmd
);

  typedef enum logic [1:0] {
    IDLE,
    LOAD,
    SCAN,
    STATUS
  } state_t;

  state_t                           state;
  logic [1:0]                       step;
  logic [sssd_pkg::DIGIT_IDX_W-1:0] idx;
  logic                             accept;
  logic                             slot_free;
  logic                             scan_last;

  assign in_ready  = (state == IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign scan_last = (({1'b0, idx} + 4'd1) == sts.scan_count);

  always_comb begin
    cmd             = '0;
    cmd.load_start  = accept && (in_kind == sssd_pkg::KIND_LOAD);
    cmd.slow_tick   = accept && (in_kind == sssd_pkg::KIND_SLOW);
    cmd.load_step   = (state == LOAD);
    cmd.step        = step;
    cmd.emit_scan   = (state == SCAN) && slot_free;
    cmd.emit_status = (state == STATUS) && slot_free;
    cmd.idx         = idx;
    cmd.scan_last   = scan_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      step      <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit_scan || cmd.emit_status) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (accept) begin
            case (in_kind)
              sssd_pkg::KIND_LOAD: begin
                state <= LOAD;
                step  <= '0;
              end
              sssd_pkg::KIND_SCAN: begin
                idx <= '0;
                if (sts.scan_count != 4'd0) begin
                  state <= SCAN;
                end
              end
              default: begin
                state <= STATUS;
              end
            endcase
          end
        end
        LOAD: begin
          step <= step + 2'd1;
          if (step == 2'd3) begin
            state <= STATUS;
          end
        end
        SCAN: begin
          if (slot_free) begin
            idx <= idx + 1'b1;
            if (scan_last) begin
              state <= IDLE;
            end
          end
        end
        STATUS: begin
          if (slot_free) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_emit_needs_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_scan || cmd.emit_status) |-> (!out_valid || out_ready))
    else $error("result issued into an occupied output register");

  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_scan && cmd.scan_last) |=> (state == IDLE && out_valid))
    else $error("scan did not finish on its last digit");

  a_load_length: assert property (@(posedge clk) disable iff (rst)
    (state == LOAD && step == 2'd3) |=> (state == STATUS))
    else $error("load did not finish after four digit steps");

  a_empty_scan: assert property (@(posedge clk) disable iff (rst)
    (accept && in_kind == sssd_pkg::KIND_SCAN && sts.scan_count == 4'd0)
      |=> (state == IDLE))
    else $error("scan with no digits produced a transaction");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/sssd_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sssd_dp #(
  parameter int unsigned NUM_DIGITS = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [1:0]                   cfg_addr,
  input  wire logic [7:0]                   cfg_wdata,
  input  wire logic [sssd_pkg::VALUE_W-1:0] low_value,
  input  wire logic [sssd_pkg::VALUE_W-1:0] high_value,
  input  wire logic                         button_pressed,
  input  wire sssd_pkg::cmd_t               cmd,
  output sssd_pkg::sts_t                    sts,
  output logic [7:0]                        segments,
  output logic [7:0]                        digit_select,
  output logic                              last,
  output logic                              disp_mode,
  output logic                              heartbeat
);

  localparam int unsigned IDX_W    = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam logic [3:0]  NUM_D4   = 4'(NUM_DIGITS);
  localparam logic [15:0] RECIP10  = 16'd52429;
  localparam int unsigned PROD_W   = sssd_pkg::VALUE_W + 16;

  logic [3:0] digits_in_use;
  logic [7:0] slow_ticks_per_phase;
  logic [3:0] hold_phases;
  logic [2:0] blink_digit_index;

  logic [7:0] seg_buf [NUM_DIGITS];
  logic [3:0] codes   [NUM_DIGITS];
  logic [7:0] tick_count;
  logic [3:0] hold_count;
  logic       mode_flag;
  logic       blink_enable;
  logic       blink_phase;
  logic       beat_flag;

  logic [sssd_pkg::VALUE_W-1:0] lo_val;
  logic [sssd_pkg::VALUE_W-1:0] hi_val;
  logic [PROD_W-1:0]            prod_lo;
  logic [PROD_W-1:0]            prod_hi;
  logic [sssd_pkg::VALUE_W-1:0] q_lo;
  logic [sssd_pkg::VALUE_W-1:0] q_hi;
  logic [3:0]                   d_lo;
  logic [3:0]                   d_hi;
  logic [2:0]                   pos_lo;
  logic [2:0]                   pos_hi;

  logic [7:0] tick_inc;
  logic [3:0] hold_inc;
  logic       phase_hit;
  logic       blink_new;
  logic       blink_in_range;
  logic [IDX_W-1:0] blink_idx;

  assign sts.scan_count = (digits_in_use > NUM_D4) ? NUM_D4 : digits_in_use;

  assign prod_lo = PROD_W'(lo_val) * PROD_W'(RECIP10);
  assign prod_hi = PROD_W'(hi_val) * PROD_W'(RECIP10);
  assign q_lo    = sssd_pkg::VALUE_W'(prod_lo >> 19);
  assign q_hi    = sssd_pkg::VALUE_W'(prod_hi >> 19);
  assign d_lo    = 4'(lo_val - ((q_lo << 3) + (q_lo << 1)));
  assign d_hi    = 4'(hi_val - ((q_hi << 3) + (q_hi << 1)));
  assign pos_lo  = {1'b0, cmd.step};
  assign pos_hi  = {1'b1, cmd.step};

  assign tick_inc       = tick_count + 8'd1;
  assign hold_inc       = hold_count + 4'd1;
  assign phase_hit      = (tick_inc >= slow_ticks_per_phase);
  assign blink_new      = ~blink_phase;
  assign blink_in_range = ({1'b0, blink_digit_index} < NUM_D4);
  assign blink_idx      = blink_digit_index[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      digits_in_use        <= 4'd6;
      slow_ticks_per_phase <= 8'd250;
      hold_phases          <= 4'd6;
      blink_digit_index    <= 3'd0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        seg_buf[i] <= 8'h00;
        codes[i]   <= 4'h0;
      end
      tick_count   <= 8'd0;
      hold_count   <= 4'd0;
      mode_flag    <= 1'b0;
      blink_enable <= 1'b0;
      blink_phase  <= 1'b0;
      beat_flag    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          sssd_pkg::REG_DIGITS_IN_USE: digits_in_use        <= cfg_wdata[3:0];
          sssd_pkg::REG_TICKS_PER_PH:  slow_ticks_per_phase <= cfg_wdata;
          sssd_pkg::REG_HOLD_PHASES:   hold_phases          <= cfg_wdata[3:0];
          sssd_pkg::REG_BLINK_INDEX:   blink_digit_index    <= cfg_wdata[2:0];
          default: ;
        endcase
      end

      if (cmd.load_step) begin
        if ({1'b0, pos_lo} < NUM_D4) begin
          codes[pos_lo[IDX_W-1:0]]   <= d_lo;
          seg_buf[pos_lo[IDX_W-1:0]] <= sssd_pkg::seg_encode(d_lo);
        end
        if ({1'b0, pos_hi} < NUM_D4) begin
          codes[pos_hi[IDX_W-1:0]]   <= d_hi;
          seg_buf[pos_hi[IDX_W-1:0]] <= sssd_pkg::seg_encode(d_hi);
        end
      end

      if (cmd.slow_tick) begin
        if (phase_hit) begin
          tick_count <= 8'd0;
          beat_flag  <= ~beat_flag;
          if (blink_enable) begin
            blink_phase <= blink_new;
            if (blink_in_range) begin
              seg_buf[blink_idx] <= blink_new ? sssd_pkg::seg_encode(codes[blink_idx])
                                              : 8'h00;
            end
          end
          if (button_pressed) begin
            if (hold_inc >= hold_phases) begin
              mode_flag    <= ~mode_flag;
              blink_enable <= ~blink_enable;
              hold_count   <= 4'd0;
            end else begin
              hold_count <= hold_inc;
            end
          end else begin
            hold_count <= 4'd0;
          end
        end else begin
          tick_count <= tick_inc;
        end
      end
    end
  end

  // digit split: one decimal digit per half each step
  always_ff @(posedge clk) begin
    if (cmd.load_start) begin
      lo_val <= low_value;
      hi_val <= high_value;
    end else if (cmd.load_step) begin
      lo_val <= q_lo;
      hi_val <= q_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_scan) begin
      segments     <= seg_buf[cmd.idx[IDX_W-1:0]];
      digit_select <= ~(8'h01 << cmd.idx);
      last         <= cmd.scan_last;
      disp_mode    <= mode_flag;
      heartbeat    <= beat_flag;
    end else if (cmd.emit_status) begin
      segments     <= 8'h00;
      digit_select <= 8'hFF;
      last         <= 1'b1;
      disp_mode    <= mode_flag;
      heartbeat    <= beat_flag;
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_seven_segment_scan_driver_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tb_seven_segment_scan_driver_core;

  localparam logic [1:0] KIND_UNUSED   = 2'd3;
  localparam int         SETTLE_CYCLES = 16;
  localparam int         MAX_SHOWN     = 10;

  // hex digit glyphs, code 0 in the lowest byte
  localparam logic [127:0] GLYPH_ROM = {
    8'h71, 8'h79, 8'h5E, 8'h39, 8'h7C, 8'h77, 8'h6F, 8'h7F,
    8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
  };

  typedef struct packed {
    logic [7:0] segments;
    logic [7:0] digit_select;
    logic       last;
    logic       disp_mode;
    logic       heartbeat;
  } scan_result_t;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;  // low_value, high_value, button_pressed
  logic [1:0]  s_axis_tuser  = '0;  // kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // segments, digit_select, disp_mode, heartbeat
  logic        m_axis_tlast;
  logic        cfg_we        = 1'b0;
  logic [1:0]  cfg_addr      = '0;
  logic [7:0]  cfg_wdata     = '0;

  int src_idle_pct   = 16;
  int sink_idle_pct  = 74;
  int mismatch_count = 0;

  scan_result_t pending_results[$];

  // predicted display state
  logic [7:0] seg_buf    [8];
  logic [3:0] digit_code [8];
  logic [7:0] tick_cnt;
  logic [3:0] hold_cnt;
  logic       mode_q;
  logic       blink_en;
  logic       blink_ph;
  logic       beat_q;
  logic [3:0] cfg_digits;
  logic [7:0] cfg_ticks;
  logic [3:0] cfg_hold;
  logic [2:0] cfg_blink_idx;

  seven_segment_scan_driver_core #(
    .NUM_DIGITS(8)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  task automatic log_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_SHOWN) begin
      $display("%0t: %s", $time, what);
    end
  endtask

  always @(posedge clk) begin
    scan_result_t got;
    scan_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.segments     = m_axis_tdata[7:0];
      got.digit_select = m_axis_tdata[15:8];
      got.last         = m_axis_tlast;
      got.disp_mode    = m_axis_tdata[16];
      got.heartbeat    = m_axis_tdata[17];
      if (pending_results.size() == 0) begin
        log_mismatch($sformatf("unexpected transaction seg=%h sel=%h last=%b mode=%b beat=%b",
                               got.segments, got.digit_select, got.last,
                               got.disp_mode, got.heartbeat));
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          log_mismatch($sformatf(
            "seg exp %h got %h, sel exp %h got %h, last exp %b got %b, mode exp %b got %b, beat exp %b got %b",
            want.segments, got.segments, want.digit_select, got.digit_select,
            want.last, got.last, want.disp_mode, got.disp_mode,
            want.heartbeat, got.heartbeat));
        end
      end
    end
  end

  function automatic logic [7:0] glyph(input logic [3:0] code);
    return GLYPH_ROM[code*8 +: 8];
  endfunction

  task automatic clear_display_state();
    for (int i = 0; i < 8; i++) begin
      seg_buf[i]    = '0;
      digit_code[i] = '0;
    end
    tick_cnt      = '0;
    hold_cnt      = '0;
    mode_q        = 1'b0;
    blink_en      = 1'b0;
    blink_ph      = 1'b0;
    beat_q        = 1'b0;
    cfg_digits    = 4'd6;
    cfg_ticks     = 8'd250;
    cfg_hold      = 4'd6;
    cfg_blink_idx = 3'd0;
  endtask

  task automatic split_bcd(input logic [13:0] value, input int base);
    int v;
    v = int'(value);
    for (int j = 0; j < 4; j++) begin
      digit_code[base+j] = 4'(v % 10);
      seg_buf[base+j]    = glyph(4'(v % 10));
      v                  = v / 10;
    end
  endtask

  task automatic push_result(input logic [7:0] seg, input logic [7:0] sel,
                             input logic last);
    scan_result_t r;
    r.segments     = seg;
    r.digit_select = sel;
    r.last         = last;
    r.disp_mode    = mode_q;
    r.heartbeat    = beat_q;
    pending_results.push_back(r);
  endtask

  task automatic predict_display(input logic [1:0] kind, input logic [13:0] lo,
                                 input logic [13:0] hi, input logic btn);
    int n;
    if (kind == sssd_pkg::KIND_SCAN) begin
      n = (cfg_digits > 8) ? 8 : int'(cfg_digits);
      for (int i = 0; i < n; i++) begin
        push_result(seg_buf[i], ~(8'b1 << i), i == n - 1);
      end
      return;
    end
    if (kind == sssd_pkg::KIND_LOAD) begin
      split_bcd(lo, 0);
      split_bcd(hi, 4);
    end else if (kind == sssd_pkg::KIND_SLOW) begin
      tick_cnt = tick_cnt + 8'd1;
      if (tick_cnt >= cfg_ticks) begin
        beat_q = ~beat_q;
        if (blink_en) begin
          blink_ph = ~blink_ph;
          seg_buf[cfg_blink_idx] = blink_ph ? glyph(digit_code[cfg_blink_idx]) : 8'h00;
        end
        if (btn) begin
          hold_cnt = hold_cnt + 4'd1;
          if (hold_cnt >= cfg_hold) begin
            mode_q   = ~mode_q;
            blink_en = ~blink_en;
            hold_cnt = '0;
          end
        end else begin
          hold_cnt = '0;
        end
        tick_cnt = '0;
      end
    end
    push_result(8'h00, 8'hFF, 1'b1);
  endtask

  task automatic send_item(input logic [1:0] kind, input logic [13:0] lo,
                           input logic [13:0] hi, input logic btn);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {3'b000, btn, hi, lo};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_display(kind, lo, hi, btn);
  endtask

  // drop valid, wait for every predicted transaction, then let the block settle
  task automatic wait_idle(input int settle);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] addr, input logic [7:0] value);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    cfg_we        <= 1'b1;
    cfg_addr      <= addr;
    cfg_wdata     <= value;
    case (addr)
      sssd_pkg::REG_DIGITS_IN_USE: cfg_digits    = value[3:0];
      sssd_pkg::REG_TICKS_PER_PH:  cfg_ticks     = value;
      sssd_pkg::REG_HOLD_PHASES:   cfg_hold      = value[3:0];
      sssd_pkg::REG_BLINK_INDEX:   cfg_blink_idx = value[2:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_config(input logic [3:0] digits, input logic [7:0] ticks,
                              input logic [3:0] hold, input logic [2:0] idx);
    write_reg(sssd_pkg::REG_DIGITS_IN_USE, {4'h0, digits});
    write_reg(sssd_pkg::REG_TICKS_PER_PH, ticks);
    write_reg(sssd_pkg::REG_HOLD_PHASES, {4'h0, hold});
    write_reg(sssd_pkg::REG_BLINK_INDEX, {5'h00, idx});
  endtask

  task automatic test_reset_defaults();
    send_item(sssd_pkg::KIND_SCAN, 14'd0, 14'd0, 1'b0);
    send_item(sssd_pkg::KIND_SLOW, 14'd0, 14'd0, 1'b1);
    wait_idle(SETTLE_CYCLES);
  endtask

  task automatic test_load_extremes();
    write_reg(sssd_pkg::REG_DIGITS_IN_USE, 8'd8);
    send_item(sssd_pkg::KIND_LOAD, 14'd0, 14'd9999, 1'b0);
    send_item(sssd_pkg::KIND_SCAN, 14'd0, 14'd0, 1'b0);
    send_item(sssd_pkg::KIND_LOAD, 14'h3FFF, 14'd10000, 1'b1);
    send_item(sssd_pkg::KIND_SCAN, 14'd0, 14'd0, 1'b0);
    send_item(sssd_pkg::KIND_LOAD, 14'd9999, 14'd0, 1'b0);
    wait_idle(SETTLE_CYCLES);
  endtask

  task automatic test_scan_widths();
    write_reg(sssd_pkg::REG_DIGITS_IN_USE, 8'd0);
    send_item(sssd_pkg::KIND_SCAN, 14'd0, 14'd0, 1'b0);
    wait_idle(SETTLE_CYCLES);
    write_reg(sssd_pkg::REG_DIGITS_IN_USE, 8'd15);
    send_item(sssd_pkg::KIND_SCAN, 14'd0, 14'd0, 1'b0);
    wait_idle(SETTLE_CYCLES);
    write_reg(sssd_pkg::REG_DIGITS_IN_USE, 8'd1);
    send_item(sssd_pkg::KIND_SCAN, 14'd0, 14'd0, 1'b0);
    wait_idle(SETTLE_CYCLES);
  endtask

  task automatic test_unused_kind();
    write_reg(sssd_pkg::REG_DIGITS_IN_USE, 8'd8);
    send_item(KIND_UNUSED, 14'h2AAA, 14'h1555, 1'b1);
    send_item(sssd_pkg::KIND_SCAN, 14'd0, 14'd0, 1'b0);
    wait_idle(SETTLE_CYCLES);
  endtask

  task automatic test_blink_and_hold();
    apply_config(4'd8, 8'd1, 4'd2, 3'd5);
    send_item(sssd_pkg::KIND_LOAD, 14'd1234, 14'd5678, 1'b0);
    send_item(sssd_pkg::KIND_SLOW, 14'd0, 14'd0, 1'b1);
    send_item(sssd_pkg::KIND_SLOW, 14'd0, 14'd0, 1'b1);
    send_item(sssd_pkg::KIND_SLOW, 14'd0, 14'd0, 1'b0);
    send_item(sssd_pkg::KIND_SLOW, 14'd0, 14'd0, 1'b0);
    send_item(sssd_pkg::KIND_SCAN, 14'd0, 14'd0, 1'b0);
    // reload while the blink digit is dark
    send_item(sssd_pkg::KIND_LOAD, 14'd4321, 14'd8765, 1'b0);
    send_item(sssd_pkg::KIND_SCAN, 14'd0, 14'd0, 1'b0);
    send_item(sssd_pkg::KIND_SLOW, 14'd0, 14'd0, 1'b1);
    send_item(sssd_pkg::KIND_SLOW, 14'd0, 14'd0, 1'b1);
    send_item(sssd_pkg::KIND_SCAN, 14'd0, 14'd0, 1'b0);
    wait_idle(SETTLE_CYCLES);
  endtask

  task automatic test_zero_periods();
    apply_config(4'd8, 8'd0, 4'd0, 3'd7);
    send_item(sssd_pkg::KIND_SLOW, 14'd0, 14'd0, 1'b1);
    send_item(sssd_pkg::KIND_SLOW, 14'd0, 14'd0, 1'b0);
    send_item(sssd_pkg::KIND_SCAN, 14'd0, 14'd0, 1'b0);
    wait_idle(SETTLE_CYCLES);
  endtask

  task automatic run_random_items(input int count);
    int   pick;
    logic btn_held;
    logic [13:0] lo;
    logic [13:0] hi;
    btn_held = 1'($urandom_range(1));
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(39) == 0) begin
        wait_idle(0);
      end
      pick = $urandom_range(99);
      if ($urandom_range(99) < 15) begin
        btn_held = ~btn_held;
      end
      if ($urandom_range(9) < 7) begin
        lo = 14'($urandom_range(9999));
        hi = 14'($urandom_range(9999));
      end else begin
        lo = 14'($urandom_range(16383));
        hi = 14'($urandom_range(16383));
      end
      if (pick < 15) begin
        send_item(sssd_pkg::KIND_LOAD, lo, hi, btn_held);
      end else if (pick < 45) begin
        send_item(sssd_pkg::KIND_SCAN, lo, hi, btn_held);
      end else if (pick < 97) begin
        send_item(sssd_pkg::KIND_SLOW, lo, hi, btn_held);
      end else begin
        send_item(KIND_UNUSED, lo, hi, btn_held);
      end
    end
  endtask

  task automatic test_random_traffic();
    logic [3:0] digits;
    logic [7:0] ticks;
    logic [3:0] hold;
    for (int round = 0; round < 3; round++) begin
      case (round)
        0: begin
          src_idle_pct  = 16;
          sink_idle_pct = 74;
        end
        1: begin
          src_idle_pct  = 74;
          sink_idle_pct = 16;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      for (int ph = 0; ph < 4; ph++) begin
        if (round == 0 && ph == 0) begin
          apply_config(4'd8, 8'd255, 4'd15, 3'd7);
        end else if (round == 0 && ph == 1) begin
          apply_config(4'd1, 8'd1, 4'd1, 3'd0);
        end else begin
          digits = ($urandom_range(4) == 0) ? 4'($urandom_range(15))
                                            : 4'($urandom_range(8, 1));
          ticks  = ($urandom_range(5) == 0) ? 8'($urandom_range(255))
                                            : 8'($urandom_range(3));
          hold   = ($urandom_range(5) == 0) ? 4'($urandom_range(15))
                                            : 4'($urandom_range(3));
          apply_config(digits, ticks, hold, 3'($urandom_range(7)));
        end
        run_random_items(25);
        wait_idle(SETTLE_CYCLES);
      end
    end
  endtask

  initial begin
    #2_000_000;
    $display("seven_segment_scan_driver_core test failed");
    $finish;
  end

  initial begin
    clear_display_state();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_load_extremes();
    test_scan_widths();
    test_unused_kind();
    test_blink_and_hold();
    test_zero_periods();
    test_random_traffic();

    wait_idle(SETTLE_CYCLES);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("seven_segment_scan_driver_core test passed");
    end else begin
      $display("seven_segment_scan_driver_core test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/sssd_pkg.sv
hw/rtl/sssd_ctrl.sv
hw/rtl/sssd_dp.sv
hw/rtl/seven_segment_scan_driver_core.sv
tb/tb_seven_segment_scan_driver_core.sv
